FILE: rtl/core/rotation_matrix_to_quaternion_defines.svh
// Assertion helpers used by the checker file.
`ifndef ROTATION_MATRIX_TO_QUATERNION_DEFINES_SVH
`define ROTATION_MATRIX_TO_QUATERNION_DEFINES_SVH

// Clocked check, switched off while reset is high.
`define RMQ_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("rmq: check failed");

// Clocked check that also runs through reset.
`define RMQ_ASSERT_NR(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("rmq: reset check failed");

`endif

FILE: rtl/core/rmq_pkg.sv
package rmq_pkg;

   localparam int IN_W      = 16;
   localparam int FRAC_W    = 14;
   localparam int PROD_W    = 2 * IN_W;
   localparam int CROSS_W   = PROD_W + 1;
   localparam int DIAG_W    = CROSS_W + 1;
   localparam int NUM_W     = DIAG_W;
   localparam int RADX_W    = DIAG_W + 2;
   localparam int RAD_W     = 32;
   localparam int ROOT_W    = 30;
   localparam int SQ_STEPS  = ROOT_W;
   localparam int MAG_W     = 32;
   localparam int Q_W       = 16;
   localparam int NUM_LANES = 3;
   localparam int NUM_COMP  = 4;
   localparam int DIV_N_W   = MAG_W + FRAC_W + 1;
   localparam int DIV_D_W   = ROOT_W + 1;

   localparam logic signed [RADX_W-1:0] ONE_Q28  = 36'sd268435456;
   localparam logic [ROOT_W:0]          HALF_RND = 31'd16384;
   localparam logic [Q_W:0]             QUO_SAT  = 17'd32768;
   localparam logic [Q_W-1:0]           POS_MAX  = 16'h7fff;

   typedef enum logic [1:0] {
      BR_TRACE,
      BR_X,
      BR_Y,
      BR_Z
   } branch_type;

   typedef struct packed {
      branch_type                          branch;
      logic [NUM_LANES-1:0]                neg;
      logic [NUM_LANES-1:0][MAG_W-1:0]     mag;
   } side_type;

   typedef struct packed {
      branch_type                          branch;
      logic [Q_W-1:0]                      half;
      logic                                zero;
      logic [NUM_LANES-1:0]                ovf;
      logic [NUM_LANES-1:0]                neg;
      logic [NUM_LANES-1:0][Q_W-1:0]       quo;
   } div_res_type;

endpackage

FILE: rtl/core/rmq_front.sv
module rmq_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               en,
   input  logic                               in_valid,
   input  logic signed [rmq_pkg::IN_W-1:0]    r0c0,
   input  logic signed [rmq_pkg::IN_W-1:0]    r0c1,
   input  logic signed [rmq_pkg::IN_W-1:0]    r0c2,
   input  logic signed [rmq_pkg::IN_W-1:0]    r1c0,
   input  logic signed [rmq_pkg::IN_W-1:0]    r1c1,
   input  logic signed [rmq_pkg::IN_W-1:0]    r1c2,
   output logic                               out_valid,
   output logic [rmq_pkg::RAD_W-1:0]          out_rad,
   output rmq_pkg::side_type                  out_side
);
   import rmq_pkg::*;

   logic                      v1_ff, v2_ff, v3_ff;
   logic signed [IN_W-1:0]    elem1_ff [6];
   logic signed [IN_W-1:0]    elem2_ff [6];
   logic signed [PROD_W-1:0]  prod_ff [6];
   logic signed [PROD_W-1:0]  prod_in [6];
   logic signed [CROSS_W-1:0] cross_ff [3];
   logic signed [CROSS_W-1:0] cross_in [3];
   logic [RAD_W-1:0]          rad_ff, rad_in;
   side_type                  side_ff, side_in;

   logic signed [DIAG_W-1:0]  m [9];
   logic signed [DIAG_W-1:0]  trace;
   logic signed [NUM_W-1:0]   n_a, n_b, n_c, n_d, n_e, n_f;
   logic signed [NUM_W-1:0]   num [NUM_LANES];
   logic signed [RADX_W-1:0]  rad_s;
   branch_type                branch;

   // stage 1: the six cross-product terms
   always_comb begin
      prod_in[0] = r0c1 * r1c2;
      prod_in[1] = r0c2 * r1c1;
      prod_in[2] = r0c2 * r1c0;
      prod_in[3] = r0c0 * r1c2;
      prod_in[4] = r0c0 * r1c1;
      prod_in[5] = r0c1 * r1c0;
   end

   // stage 2: third row
   always_comb begin
      cross_in[0] = CROSS_W'(prod_ff[0]) - CROSS_W'(prod_ff[1]);
      cross_in[1] = CROSS_W'(prod_ff[2]) - CROSS_W'(prod_ff[3]);
      cross_in[2] = CROSS_W'(prod_ff[4]) - CROSS_W'(prod_ff[5]);
   end

   // stage 3: trace, branch pick, radicand and numerators
   always_comb begin
      for (int i = 0; i < 6; i++) begin
         m[i] = DIAG_W'(elem2_ff[i]) <<< FRAC_W;
      end
      for (int i = 0; i < 3; i++) begin
         m[6 + i] = DIAG_W'(cross_ff[i]);
      end
      trace = m[0] + m[4] + m[8];
      n_a = m[7] - m[5];
      n_b = m[2] - m[6];
      n_c = m[3] - m[1];
      n_d = m[1] + m[3];
      n_e = m[2] + m[6];
      n_f = m[5] + m[7];

      if (trace > 0) begin
         branch = BR_TRACE;
      end else if (m[0] > m[4] && m[0] > m[8]) begin
         branch = BR_X;
      end else if (m[4] > m[8]) begin
         branch = BR_Y;
      end else begin
         branch = BR_Z;
      end

      case (branch)
         BR_TRACE: begin
            rad_s  = RADX_W'(trace) + ONE_Q28;
            num[0] = n_a;
            num[1] = n_b;
            num[2] = n_c;
         end
         BR_X: begin
            rad_s  = ONE_Q28 + RADX_W'(m[0]) - RADX_W'(m[4]) - RADX_W'(m[8]);
            num[0] = n_a;
            num[1] = n_d;
            num[2] = n_e;
         end
         BR_Y: begin
            rad_s  = ONE_Q28 + RADX_W'(m[4]) - RADX_W'(m[0]) - RADX_W'(m[8]);
            num[0] = n_b;
            num[1] = n_d;
            num[2] = n_f;
         end
         default: begin
            rad_s  = ONE_Q28 + RADX_W'(m[8]) - RADX_W'(m[0]) - RADX_W'(m[4]);
            num[0] = n_c;
            num[1] = n_e;
            num[2] = n_f;
         end
      endcase

      // clamp a negative radicand to zero
      rad_in = (rad_s > 0) ? rad_s[RAD_W-1:0] : '0;

      side_in.branch = branch;
      for (int i = 0; i < NUM_LANES; i++) begin
         side_in.neg[i] = num[i][NUM_W-1];
         side_in.mag[i] = num[i][NUM_W-1] ? MAG_W'(-num[i]) : MAG_W'(num[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         elem1_ff[0] <= r0c0;
         elem1_ff[1] <= r0c1;
         elem1_ff[2] <= r0c2;
         elem1_ff[3] <= r1c0;
         elem1_ff[4] <= r1c1;
         elem1_ff[5] <= r1c2;
         prod_ff     <= prod_in;
         elem2_ff    <= elem1_ff;
         cross_ff    <= cross_in;
         rad_ff      <= rad_in;
         side_ff     <= side_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_rad   = rad_ff;
   assign out_side  = side_ff;

endmodule

FILE: rtl/core/rmq_sqrt.sv
module rmq_sqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic [rmq_pkg::RAD_W-1:0]   in_rad,
   input  rmq_pkg::side_type           in_side,
   output logic                        out_valid,
   output logic [rmq_pkg::ROOT_W-1:0]  out_root,
   output rmq_pkg::side_type           out_side
);
   import rmq_pkg::*;

   logic              valid_ff [SQ_STEPS];
   logic [RAD_W-1:0]  rad_ff   [SQ_STEPS];
   logic [ROOT_W:0]   rem_ff   [SQ_STEPS];
   logic [ROOT_W-1:0] root_ff  [SQ_STEPS];
   side_type          side_ff  [SQ_STEPS];

   // one root bit per stage; radicand pairs shift out of the top
   for (genvar s = 0; s < SQ_STEPS; s++) begin : g_step
      logic              v_src;
      logic [RAD_W-1:0]  rad_src, rad_in;
      logic [ROOT_W:0]   rem_src, rem_in;
      logic [ROOT_W-1:0] root_src, root_in;
      side_type          side_src;
      logic [ROOT_W+2:0] rem_sh, trial;

      if (s == 0) begin : g_first
         assign v_src    = in_valid;
         assign rad_src  = in_rad;
         assign rem_src  = '0;
         assign root_src = '0;
         assign side_src = in_side;
      end else begin : g_next
         assign v_src    = valid_ff[s-1];
         assign rad_src  = rad_ff[s-1];
         assign rem_src  = rem_ff[s-1];
         assign root_src = root_ff[s-1];
         assign side_src = side_ff[s-1];
      end

      always_comb begin
         rem_sh = {rem_src, rad_src[RAD_W-1 -: 2]};
         trial  = {1'b0, root_src, 2'b01};
         rad_in = {rad_src[RAD_W-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = (ROOT_W+1)'(rem_sh - trial);
            root_in = {root_src[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = (ROOT_W+1)'(rem_sh);
            root_in = {root_src[ROOT_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (en) begin
            valid_ff[s] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rad_ff[s]  <= rad_in;
            rem_ff[s]  <= rem_in;
            root_ff[s] <= root_in;
            side_ff[s] <= side_src;
         end
      end
   end

   assign out_valid = valid_ff[SQ_STEPS-1];
   assign out_root  = root_ff[SQ_STEPS-1];
   assign out_side  = side_ff[SQ_STEPS-1];

endmodule

FILE: rtl/core/rmq_div.sv
module rmq_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic [rmq_pkg::ROOT_W-1:0]  in_root,
   input  rmq_pkg::side_type           in_side,
   output logic                        out_valid,
   output rmq_pkg::div_res_type        out_res
);
   import rmq_pkg::*;

   localparam int STAGES = Q_W + 1;

   logic                                valid_ff [STAGES];
   logic [NUM_LANES-1:0][DIV_D_W-1:0]   rem_ff   [STAGES];
   logic [NUM_LANES-1:0][Q_W-1:0]       low_ff   [STAGES];
   logic [DIV_D_W-1:0]                  den_ff   [STAGES];
   div_res_type                         res_ff   [STAGES];

   // setup: numerator 2*mag*2^13 + r over 2r, overflow when quotient >= 2^16
   logic [NUM_LANES-1:0][DIV_D_W-1:0]   rem_in;
   logic [NUM_LANES-1:0][Q_W-1:0]       low_in;
   logic [DIV_D_W-1:0]                  den_in;
   div_res_type                         res_in;
   logic [DIV_N_W-1:0]                  n_full [NUM_LANES];
   logic [ROOT_W:0]                     hsum;
   logic [Q_W-1:0]                      hq;

   always_comb begin
      den_in        = {in_root, 1'b0};
      hsum          = (ROOT_W+1)'(in_root) + HALF_RND;
      hq            = hsum[ROOT_W -: Q_W];
      res_in.branch = in_side.branch;
      res_in.half   = hq[Q_W-1] ? POS_MAX : hq;
      res_in.zero   = (in_root == '0);
      res_in.neg    = in_side.neg;
      res_in.quo    = '0;
      for (int i = 0; i < NUM_LANES; i++) begin
         n_full[i]     = DIV_N_W'({in_side.mag[i], FRAC_W'(0)}) + DIV_N_W'(in_root);
         rem_in[i]     = n_full[i][DIV_N_W-1:Q_W];
         low_in[i]     = n_full[i][Q_W-1:0];
         res_in.ovf[i] = (n_full[i][DIV_N_W-1:Q_W] >= den_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= rem_in;
         low_ff[0] <= low_in;
         den_ff[0] <= den_in;
         res_ff[0] <= res_in;
      end
   end

   // restoring steps, one quotient bit per stage for all three lanes
   for (genvar s = 1; s < STAGES; s++) begin : g_step
      logic [NUM_LANES-1:0][DIV_D_W-1:0] st_rem_in;
      logic [NUM_LANES-1:0][Q_W-1:0]     st_low_in;
      div_res_type                       st_res_in;
      logic [DIV_D_W:0]                  rem_sh [NUM_LANES];

      always_comb begin
         st_res_in = res_ff[s-1];
         for (int i = 0; i < NUM_LANES; i++) begin
            rem_sh[i]    = {rem_ff[s-1][i], low_ff[s-1][i][Q_W-1]};
            st_low_in[i] = {low_ff[s-1][i][Q_W-2:0], 1'b0};
            if (rem_sh[i] >= {1'b0, den_ff[s-1]}) begin
               st_rem_in[i]     = DIV_D_W'(rem_sh[i] - {1'b0, den_ff[s-1]});
               st_res_in.quo[i] = {res_ff[s-1].quo[i][Q_W-2:0], 1'b1};
            end else begin
               st_rem_in[i]     = DIV_D_W'(rem_sh[i]);
               st_res_in.quo[i] = {res_ff[s-1].quo[i][Q_W-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (en) begin
            valid_ff[s] <= valid_ff[s-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s] <= st_rem_in;
            low_ff[s] <= st_low_in;
            den_ff[s] <= den_ff[s-1];
            res_ff[s] <= st_res_in;
         end
      end
   end

   assign out_valid = valid_ff[STAGES-1];
   assign out_res   = res_ff[STAGES-1];

endmodule

FILE: rtl/core/rmq_out.sv
module rmq_out (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            en,
   input  logic                            in_valid,
   input  rmq_pkg::div_res_type            in_res,
   output logic                            rsp_valid,
   output logic signed [rmq_pkg::Q_W-1:0]  rsp_quat_w,
   output logic signed [rmq_pkg::Q_W-1:0]  rsp_quat_x,
   output logic signed [rmq_pkg::Q_W-1:0]  rsp_quat_y,
   output logic signed [rmq_pkg::Q_W-1:0]  rsp_quat_z
);
   import rmq_pkg::*;

   logic                 valid_ff;
   logic [Q_W-1:0]       comp_ff [NUM_COMP];
   logic [Q_W-1:0]       comp_in [NUM_COMP];
   logic [Q_W:0]         qc      [NUM_LANES];
   logic [Q_W-1:0]       lane    [NUM_LANES];
   logic [1:0]           pick;

   always_comb begin
      for (int i = 0; i < NUM_LANES; i++) begin
         if (in_res.zero) begin
            qc[i] = '0;
         end else if (in_res.ovf[i] || ({1'b0, in_res.quo[i]} > QUO_SAT)) begin
            qc[i] = QUO_SAT;
         end else begin
            qc[i] = {1'b0, in_res.quo[i]};
         end
         // qc never exceeds 2^15, so its top data bit marks the positive bound
         if (in_res.neg[i]) begin
            lane[i] = Q_W'(-qc[i]);
         end else begin
            lane[i] = qc[i][Q_W-1] ? POS_MAX : qc[i][Q_W-1:0];
         end
      end
      // the diagonal slot takes the half root, the others fill in order
      for (int j = 0; j < NUM_COMP; j++) begin
         if (2'(j) == in_res.branch) begin
            pick       = '0;
            comp_in[j] = in_res.half;
         end else begin
            pick       = (2'(j) < in_res.branch) ? 2'(j) : 2'(j - 1);
            comp_in[j] = lane[pick];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         comp_ff <= comp_in;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_quat_w = comp_ff[0];
   assign rsp_quat_x = comp_ff[1];
   assign rsp_quat_y = comp_ff[2];
   assign rsp_quat_z = comp_ff[3];

endmodule

FILE: rtl/core/rotation_matrix_to_quaternion.sv
// An accepted req beat passes 3 front stages, 30 root stages, 17 divider stages
// and 1 output register on its way to its rsp beat.
// Throughput: one matrix per cycle; the whole pipeline holds while a result
// waits at the output register, so nothing is dropped or repeated.
// Reset (synchronous, active high) clears every stage valid bit; data is kept.
module rotation_matrix_to_quaternion (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic signed [rmq_pkg::IN_W-1:0] req_r0c0,
   input  logic signed [rmq_pkg::IN_W-1:0] req_r0c1,
   input  logic signed [rmq_pkg::IN_W-1:0] req_r0c2,
   input  logic signed [rmq_pkg::IN_W-1:0] req_r1c0,
   input  logic signed [rmq_pkg::IN_W-1:0] req_r1c1,
   input  logic signed [rmq_pkg::IN_W-1:0] req_r1c2,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic signed [rmq_pkg::Q_W-1:0]  rsp_quat_w,
   output logic signed [rmq_pkg::Q_W-1:0]  rsp_quat_x,
   output logic signed [rmq_pkg::Q_W-1:0]  rsp_quat_y,
   output logic signed [rmq_pkg::Q_W-1:0]  rsp_quat_z
);
   import rmq_pkg::*;

   logic              en;
   logic              fr_valid, sq_valid, dv_valid;
   logic [RAD_W-1:0]  fr_rad;
   side_type          fr_side, sq_side;
   logic [ROOT_W-1:0] sq_root;
   div_res_type       dv_res;

   // advance everything unless a finished beat is stuck at the output
   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   rmq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .r0c0      (req_r0c0),
      .r0c1      (req_r0c1),
      .r0c2      (req_r0c2),
      .r1c0      (req_r1c0),
      .r1c1      (req_r1c1),
      .r1c2      (req_r1c2),
      .out_valid (fr_valid),
      .out_rad   (fr_rad),
      .out_side  (fr_side)
   );

   rmq_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (fr_valid),
      .in_rad    (fr_rad),
      .in_side   (fr_side),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   rmq_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sq_valid),
      .in_root   (sq_root),
      .in_side   (sq_side),
      .out_valid (dv_valid),
      .out_res   (dv_res)
   );

   rmq_out u_out (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (dv_valid),
      .in_res     (dv_res),
      .rsp_valid  (rsp_valid),
      .rsp_quat_w (rsp_quat_w),
      .rsp_quat_x (rsp_quat_x),
      .rsp_quat_y (rsp_quat_y),
      .rsp_quat_z (rsp_quat_z)
   );

endmodule

FILE: rtl/core/rmq_checker.sv
`include "rotation_matrix_to_quaternion_defines.svh"

module rmq_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic signed [rmq_pkg::Q_W-1:0]  rsp_quat_w,
   input logic signed [rmq_pkg::Q_W-1:0]  rsp_quat_x,
   input logic signed [rmq_pkg::Q_W-1:0]  rsp_quat_y,
   input logic signed [rmq_pkg::Q_W-1:0]  rsp_quat_z
);
   import rmq_pkg::*;

   logic [4*Q_W-1:0] rsp_payload;

   assign rsp_payload = {rsp_quat_w, rsp_quat_x, rsp_quat_y, rsp_quat_z};

   // output stage empties on reset, so the input side opens right after
   `RMQ_ASSERT_NR(a_reset_empties, clock, reset |=> (!rsp_valid && req_ready))

   // input stalls exactly when a result beat is held back
   `RMQ_ASSERT(a_ready_tracks_out, clock, reset, req_ready == (!rsp_valid || rsp_ready))

   // a held result beat keeps its payload
   `RMQ_ASSERT(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_payload)))

   // from an empty output and an idle input, the block goes on to either accept input or show a result
   `RMQ_ASSERT(a_no_spurious, clock, reset, (!rsp_valid && !req_valid && !rsp_ready) |=> (req_ready || rsp_valid))

endmodule

bind rotation_matrix_to_quaternion rmq_checker u_rmq_checker (.*);
